// ===== rtl/rwaa_pkg.sv =====
// ============================================================================
// rwaa_pkg : shared types and constants of the wander/avoid velocity arbiter
// Field widths, configuration register indices, the per-tick item, result and
// persistent state records, and the fixed angle and saturation limits.
// ============================================================================
package rwaa_pkg;

    // Field widths
    localparam int POS_W   = 21;
    localparam int HDG_W   = 13;
    localparam int DIST_W  = 14;
    localparam int MLIN_W  = 11;
    localparam int MANG_W  = 13;
    localparam int RND_W   = 10;
    localparam int FS_W    = 10;
    localparam int TR_W    = 12;
    localparam int DB_W    = 7;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_SPEED     = 3'd0,
        CFG_TURN_RATE         = 3'd1,
        CFG_CLEAR_DISTANCE    = 3'd2,
        CFG_SWERVE_DISTANCE   = 3'd3,
        CFG_BLOCKED_DISTANCE  = 3'd4,
        CFG_WANDER_STEP       = 3'd5,
        CFG_OVERRIDE_DEADBAND = 3'd6
    } t_cfg_idx;

    // Register reset values
    localparam logic [FS_W-1:0]   FORWARD_SPEED_RST     = 10'd300;
    localparam logic [TR_W-1:0]   TURN_RATE_RST         = 12'd1000;
    localparam logic [DIST_W-1:0] CLEAR_DISTANCE_RST    = 14'd600;
    localparam logic [DIST_W-1:0] SWERVE_DISTANCE_RST   = 14'd305;
    localparam logic [DIST_W-1:0] BLOCKED_DISTANCE_RST  = 14'd400;
    localparam logic [DIST_W-1:0] WANDER_STEP_RST       = 14'd305;
    localparam logic [DB_W-1:0]   OVERRIDE_DEADBAND_RST = 7'd10;

    // Angle and saturation limits
    localparam logic signed [14:0]       WRAP_MRAD    = 15'sd6280;
    localparam logic signed [HDG_W-1:0]  REVERSE_TURN = -13'sd3140;
    localparam logic signed [11:0]       LIN_LIMIT    = 12'sd1000;
    localparam logic signed [13:0]       ANG_LIMIT    = 14'sd4000;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x_mm;
        logic signed [POS_W-1:0]  pos_y_mm;
        logic signed [HDG_W-1:0]  heading_mrad;
        logic [DIST_W-1:0]        left_near_mm;
        logic [DIST_W-1:0]        right_near_mm;
        logic signed [MLIN_W-1:0] manual_linear;
        logic signed [MANG_W-1:0] manual_angular;
        logic                     bumper_pressed;
        logic signed [RND_W-1:0]  random_turn_mrad;
    } t_item;

    typedef struct packed {
        logic [FS_W-1:0]   forward_speed;
        logic [TR_W-1:0]   turn_rate;
        logic [DIST_W-1:0] clear_distance;
        logic [DIST_W-1:0] swerve_distance;
        logic [DIST_W-1:0] blocked_distance;
        logic [DIST_W-1:0] wander_step;
        logic [DB_W-1:0]   override_deadband;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] anchor_x;
        logic signed [POS_W-1:0] anchor_y;
        logic signed [HDG_W-1:0] anchor_heading;
        logic signed [HDG_W-1:0] pending_turn;
        logic                    in_place_turn;
        logic                    anchored;
    } t_state;

    typedef struct packed {
        logic signed [MLIN_W-1:0] linear_cmd;
        logic signed [MANG_W-1:0] angular_cmd;
        logic                     turn_committed;
    } t_result;

endpackage

// ===== rtl/rwaa_decide.sv =====
// ============================================================================
// rwaa_decide : one control tick of the wander/avoid arbitration
// Takes the registered item, the configuration and the persistent state and
// produces the velocity command and the state left behind for the next tick.
// ============================================================================
module rwaa_decide (
    input  rwaa_pkg::t_item   i_item,
    input  rwaa_pkg::t_cfg    i_cfg,
    input  rwaa_pkg::t_state  i_state,
    output rwaa_pkg::t_state  o_state,
    output rwaa_pkg::t_result o_result
);

    // Work through the behaviours in rising priority
    always_comb begin
        logic signed [rwaa_pkg::POS_W-1:0] ax;
        logic signed [rwaa_pkg::POS_W-1:0] ay;
        logic signed [rwaa_pkg::HDG_W-1:0] ah;
        logic signed [rwaa_pkg::HDG_W-1:0] pend;
        logic                              ipt;
        logic signed [21:0]                dx;
        logic signed [21:0]                dy;
        logic signed [43:0]                sq_x;
        logic signed [43:0]                sq_y;
        logic [43:0]                       dd;
        logic [27:0]                       ws_sq;
        logic                              wander;
        logic signed [11:0]                lin;
        logic signed [13:0]                ang;
        logic signed [13:0]                tr_s;
        logic signed [14:0]                diff;
        logic signed [14:0]                wp1;
        logic signed [14:0]                wp;
        logic signed [14:0]                wn1;
        logic signed [14:0]                wn;
        logic signed [14:0]                pend_w;
        logic signed [11:0]                ml_mag;
        logic signed [13:0]                ma_mag;
        logic signed [11:0]                db_l;
        logic signed [13:0]                db_a;
        logic                              teleop;

        // Capture the start pose on the first tick
        ax   = i_state.anchored ? i_state.anchor_x       : i_item.pos_x_mm;
        ay   = i_state.anchored ? i_state.anchor_y       : i_item.pos_y_mm;
        ah   = i_state.anchored ? i_state.anchor_heading : i_item.heading_mrad;
        pend = i_state.pending_turn;
        ipt  = i_state.in_place_turn;

        // Squared travel against squared wander step
        dx    = {i_item.pos_x_mm[rwaa_pkg::POS_W-1], i_item.pos_x_mm}
              - {ax[rwaa_pkg::POS_W-1], ax};
        dy    = {i_item.pos_y_mm[rwaa_pkg::POS_W-1], i_item.pos_y_mm}
              - {ay[rwaa_pkg::POS_W-1], ay};
        sq_x  = dx * dx;
        sq_y  = dy * dy;
        dd    = 44'(sq_x) + 44'(sq_y);
        ws_sq = {14'd0, i_cfg.wander_step} * {14'd0, i_cfg.wander_step};

        wander = (dd > {16'd0, ws_sq}) && !ipt
              && (i_item.left_near_mm > i_cfg.clear_distance)
              && (i_item.right_near_mm > i_cfg.clear_distance);
        if (wander) begin
            pend = {{(rwaa_pkg::HDG_W-rwaa_pkg::RND_W){i_item.random_turn_mrad[rwaa_pkg::RND_W-1]}},
                    i_item.random_turn_mrad};
            ah   = i_item.heading_mrad;
            ax   = i_item.pos_x_mm;
            ay   = i_item.pos_y_mm;
        end

        // Cruise, or swerve from a one-sided obstacle
        tr_s = {2'b00, i_cfg.turn_rate};
        lin  = {2'b00, i_cfg.forward_speed};
        ang  = 14'sd0;
        if (i_item.left_near_mm < i_cfg.swerve_distance) begin
            ang = -tr_s;
            lin = {3'b000, i_cfg.forward_speed[rwaa_pkg::FS_W-1:1]};
        end else if (i_item.right_near_mm < i_cfg.swerve_distance) begin
            ang = tr_s;
            lin = {3'b000, i_cfg.forward_speed[rwaa_pkg::FS_W-1:1]};
        end

        // Both sides blocked: commit to a reverse turn
        if ((i_item.left_near_mm < i_cfg.blocked_distance)
                && (i_item.right_near_mm < i_cfg.blocked_distance) && !ipt) begin
            pend = rwaa_pkg::REVERSE_TURN;
            ah   = i_item.heading_mrad;
            ipt  = 1'b1;
        end

        if (ipt) begin
            lin = 12'sd0;
        end

        // Heading progress wrapped both ways
        diff = {{2{i_item.heading_mrad[rwaa_pkg::HDG_W-1]}}, i_item.heading_mrad}
             - {{2{ah[rwaa_pkg::HDG_W-1]}}, ah};
        wp1  = (diff > rwaa_pkg::WRAP_MRAD) ? diff - rwaa_pkg::WRAP_MRAD : diff;
        wp   = (wp1 < 15'sd0) ? wp1 + rwaa_pkg::WRAP_MRAD : wp1;
        wn1  = (diff > 15'sd0) ? diff - rwaa_pkg::WRAP_MRAD : diff;
        wn   = (wn1 < -rwaa_pkg::WRAP_MRAD) ? wn1 + rwaa_pkg::WRAP_MRAD : wn1;
        pend_w = {{2{pend[rwaa_pkg::HDG_W-1]}}, pend};

        // Carry on with a pending turn or finish it
        if (pend_w > 15'sd0) begin
            if (pend_w > wp) begin
                ang = tr_s;
            end else begin
                pend = 13'sd0;
                ipt  = 1'b0;
            end
        end else if (pend_w < 15'sd0) begin
            if (pend_w < wn) begin
                ang = -tr_s;
            end else begin
                pend = 13'sd0;
                ipt  = 1'b0;
            end
        end

        // Teleop override above the deadband
        ml_mag = i_item.manual_linear[rwaa_pkg::MLIN_W-1]
               ? -{i_item.manual_linear[rwaa_pkg::MLIN_W-1], i_item.manual_linear}
               :  {i_item.manual_linear[rwaa_pkg::MLIN_W-1], i_item.manual_linear};
        ma_mag = i_item.manual_angular[rwaa_pkg::MANG_W-1]
               ? -{i_item.manual_angular[rwaa_pkg::MANG_W-1], i_item.manual_angular}
               :  {i_item.manual_angular[rwaa_pkg::MANG_W-1], i_item.manual_angular};
        db_l   = {5'd0, i_cfg.override_deadband};
        db_a   = {7'd0, i_cfg.override_deadband};
        teleop = (ml_mag > db_l) || (ma_mag > db_a);
        if (teleop) begin
            lin  = {i_item.manual_linear[rwaa_pkg::MLIN_W-1], i_item.manual_linear};
            ang  = {i_item.manual_angular[rwaa_pkg::MANG_W-1], i_item.manual_angular};
            pend = 13'sd0;
            ipt  = 1'b0;
        end

        // Bumper stops linear motion only
        if (i_item.bumper_pressed) begin
            lin = 12'sd0;
        end

        // Saturate the command
        if (lin > rwaa_pkg::LIN_LIMIT) begin
            lin = rwaa_pkg::LIN_LIMIT;
        end else if (lin < -rwaa_pkg::LIN_LIMIT) begin
            lin = -rwaa_pkg::LIN_LIMIT;
        end
        if (ang > rwaa_pkg::ANG_LIMIT) begin
            ang = rwaa_pkg::ANG_LIMIT;
        end else if (ang < -rwaa_pkg::ANG_LIMIT) begin
            ang = -rwaa_pkg::ANG_LIMIT;
        end

        o_state.anchor_x       = ax;
        o_state.anchor_y       = ay;
        o_state.anchor_heading = ah;
        o_state.pending_turn   = pend;
        o_state.in_place_turn  = ipt;
        o_state.anchored       = 1'b1;

        o_result.linear_cmd     = lin[rwaa_pkg::MLIN_W-1:0];
        o_result.angular_cmd    = ang[rwaa_pkg::MANG_W-1:0];
        o_result.turn_committed = ipt;
    end

endmodule

// ===== rtl/reactive_wander_avoid_arbiter_top.sv =====
// ============================================================================
// reactive_wander_avoid_arbiter_top : wander/avoid velocity command arbiter
// Turns one control tick (pose, obstacle distances, teleop, bumper, random
// offset) into one linear/angular velocity command.
// ============================================================================
// Usage:
//   s_axis carries one control tick per transaction; m_axis returns exactly
//   one velocity command for each tick, in order. The cfg channel writes the
//   seven tuning registers (index 0..6, others ignored) and is always ready;
//   write only while no tick is in flight.
//   Path: a taken tick fills the input register, and its command reaches
//   m_axis when the result register takes it from the arbitration stage.
//   Throughput: one tick per cycle while the receiver keeps up, set by the
//   single arbitration stage, whose state update (travel anchor, pending turn)
//   feeds back into the very next tick.
//   The squared travel, the wrap compares and the saturation all sit in that
//   one stage between the input and the result register.
//   Reset (synchronous, active low) restores the register defaults, clears the
//   turn state and re-arms capture of the start pose on the next tick.
//   If the receiver stalls, the held command stays on m_axis, one more tick
//   is taken into the input register, then s_axis_tready drops until the
//   command moves on.
// ============================================================================
module reactive_wander_avoid_arbiter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata, lowest bit up: pos_x_mm[20:0], pos_y_mm[41:21], heading_mrad[54:42],
    // left_near_mm[68:55], right_near_mm[82:69], manual_linear[93:83],
    // manual_angular[106:94], bumper_pressed[107], random_turn_mrad[117:108], pad
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rwaa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tdata, lowest bit up: linear_cmd[10:0], angular_cmd[23:11],
    // turn_committed[24], pad
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rwaa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rwaa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rwaa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rwaa_pkg::t_cfg    r_cfg;
    rwaa_pkg::t_item   r_item;
    logic              r_in_valid;
    rwaa_pkg::t_state  r_state;
    rwaa_pkg::t_state  n_state;
    rwaa_pkg::t_result n_result;
    rwaa_pkg::t_result r_result;
    logic              r_out_valid;
    logic              advance;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_speed     <= rwaa_pkg::FORWARD_SPEED_RST;
            r_cfg.turn_rate         <= rwaa_pkg::TURN_RATE_RST;
            r_cfg.clear_distance    <= rwaa_pkg::CLEAR_DISTANCE_RST;
            r_cfg.swerve_distance   <= rwaa_pkg::SWERVE_DISTANCE_RST;
            r_cfg.blocked_distance  <= rwaa_pkg::BLOCKED_DISTANCE_RST;
            r_cfg.wander_step       <= rwaa_pkg::WANDER_STEP_RST;
            r_cfg.override_deadband <= rwaa_pkg::OVERRIDE_DEADBAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rwaa_pkg::t_cfg_idx'(i_cfg_index))
                rwaa_pkg::CFG_FORWARD_SPEED:
                    r_cfg.forward_speed <= i_cfg_data[rwaa_pkg::FS_W-1:0];
                rwaa_pkg::CFG_TURN_RATE:
                    r_cfg.turn_rate <= i_cfg_data[rwaa_pkg::TR_W-1:0];
                rwaa_pkg::CFG_CLEAR_DISTANCE:
                    r_cfg.clear_distance <= i_cfg_data;
                rwaa_pkg::CFG_SWERVE_DISTANCE:
                    r_cfg.swerve_distance <= i_cfg_data;
                rwaa_pkg::CFG_BLOCKED_DISTANCE:
                    r_cfg.blocked_distance <= i_cfg_data;
                rwaa_pkg::CFG_WANDER_STEP:
                    r_cfg.wander_step <= i_cfg_data;
                rwaa_pkg::CFG_OVERRIDE_DEADBAND:
                    r_cfg.override_deadband <= i_cfg_data[rwaa_pkg::DB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the arbitration stage advances when the result slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.pos_x_mm         <= s_axis_tdata[20:0];
            r_item.pos_y_mm         <= s_axis_tdata[41:21];
            r_item.heading_mrad     <= s_axis_tdata[54:42];
            r_item.left_near_mm     <= s_axis_tdata[68:55];
            r_item.right_near_mm    <= s_axis_tdata[82:69];
            r_item.manual_linear    <= s_axis_tdata[93:83];
            r_item.manual_angular   <= s_axis_tdata[106:94];
            r_item.bumper_pressed   <= s_axis_tdata[107];
            r_item.random_turn_mrad <= s_axis_tdata[117:108];
        end
    end

    rwaa_decide u_decide (
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Persistent arbitration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_result.turn_committed, r_result.angular_cmd,
                            r_result.linear_cmd};

    // A committed turn only ever holds the fixed reverse turn
    a_commit_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_place_turn |-> (r_state.pending_turn == rwaa_pkg::REVERSE_TURN))
        else $error("committed turn without reverse pending turn");

    // A committed turn never drives forward
    a_commit_still : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.turn_committed) |-> (r_result.linear_cmd == 11'sd0))
        else $error("linear command during committed turn");

    // Commands stay within the saturation limits
    a_lin_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_result.linear_cmd <= 11'sd1000)
                      && (r_result.linear_cmd >= -11'sd1000)))
        else $error("linear command out of range");

    a_ang_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_result.angular_cmd <= 13'sd4000)
                      && (r_result.angular_cmd >= -13'sd4000)))
        else $error("angular command out of range");

    // State only moves when a tick is processed
    a_state_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && $past(i_rst_n)) |=> $stable(r_state))
        else $error("state changed without a processed tick");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb : self-checking bench for the wander/avoid velocity arbiter
// Drives control ticks over the input stream and checks every velocity
// command against an in-bench arbitration predictor. A directed table covers
// start-pose capture, wander, swerve, committed turns, heading wrap, teleop,
// bumper and saturation. Random roaming runs follow under several tunings
// and idle patterns on both stream sides.
// ============================================================================
module tb;

    localparam int POS_W       = rwaa_pkg::POS_W;
    localparam int HDG_W       = rwaa_pkg::HDG_W;
    localparam int DIST_W      = rwaa_pkg::DIST_W;
    localparam int MLIN_W      = rwaa_pkg::MLIN_W;
    localparam int MANG_W      = rwaa_pkg::MANG_W;
    localparam int RND_W       = rwaa_pkg::RND_W;
    localparam int FS_W        = rwaa_pkg::FS_W;
    localparam int TR_W        = rwaa_pkg::TR_W;
    localparam int DB_W        = rwaa_pkg::DB_W;
    localparam int CFG_IDX_W   = rwaa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = rwaa_pkg::CFG_DATA_W;
    localparam int IN_TDATA_W  = rwaa_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rwaa_pkg::OUT_TDATA_W;

    localparam int            CYCLE_LIMIT    = 400000;
    localparam int            FULL_TURN_MRAD = 6283;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam longint        WRAP_L    = rwaa_pkg::WRAP_MRAD;
    localparam longint        TURN_BACK = rwaa_pkg::REVERSE_TURN;
    localparam longint        LIN_CAP   = rwaa_pkg::LIN_LIMIT;
    localparam longint        ANG_CAP   = rwaa_pkg::ANG_LIMIT;

    typedef struct {
        rwaa_pkg::t_item   tick;
        bit                typed;
        rwaa_pkg::t_result want;
    } t_tick_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // predictor state and tuning
    rwaa_pkg::t_cfg tune = '{forward_speed: rwaa_pkg::FORWARD_SPEED_RST,
                             turn_rate: rwaa_pkg::TURN_RATE_RST,
                             clear_distance: rwaa_pkg::CLEAR_DISTANCE_RST,
                             swerve_distance: rwaa_pkg::SWERVE_DISTANCE_RST,
                             blocked_distance: rwaa_pkg::BLOCKED_DISTANCE_RST,
                             wander_step: rwaa_pkg::WANDER_STEP_RST,
                             override_deadband: rwaa_pkg::OVERRIDE_DEADBAND_RST};
    longint pose_ref_x    = 0;
    longint pose_ref_y    = 0;
    longint turn_base_hd  = 0;
    longint turn_left     = 0;
    bit     spin_active   = 1'b0;
    bit     pose_captured = 1'b0;
    longint last_ang_cmd  = 0;

    // roaming pose for the random part
    int walk_x  = 0;
    int walk_y  = 0;
    int walk_hd = 0;

    rwaa_pkg::t_result cmd_due_q[$];
    t_tick_row         directed_q[$];
    int                errors      = 0;
    int                cycle_count = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;

    reactive_wander_avoid_arbiter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic rwaa_pkg::t_item make_tick(longint px, longint py, longint hd,
                                                  longint lft, longint rgt, longint ml,
                                                  longint ma, bit bump, longint rnd);
        rwaa_pkg::t_item t;
        t.pos_x_mm         = px[POS_W-1:0];
        t.pos_y_mm         = py[POS_W-1:0];
        t.heading_mrad     = hd[HDG_W-1:0];
        t.left_near_mm     = lft[DIST_W-1:0];
        t.right_near_mm    = rgt[DIST_W-1:0];
        t.manual_linear    = ml[MLIN_W-1:0];
        t.manual_angular   = ma[MANG_W-1:0];
        t.bumper_pressed   = bump;
        t.random_turn_mrad = rnd[RND_W-1:0];
        return t;
    endfunction

    function automatic rwaa_pkg::t_result make_cmd(longint lin, longint ang, bit committed);
        rwaa_pkg::t_result r;
        r.linear_cmd     = lin[MLIN_W-1:0];
        r.angular_cmd    = ang[MANG_W-1:0];
        r.turn_committed = committed;
        return r;
    endfunction

    // Arbitrate one control tick and advance the predictor state
    function automatic rwaa_pkg::t_result arbitrate_tick(rwaa_pkg::t_item t);
        longint px, py, hd, lft, rgt, ml, ma, rnd;
        longint fs, tr, ws, db, lin, ang, dx, dy, span;
        px  = $signed(t.pos_x_mm);
        py  = $signed(t.pos_y_mm);
        hd  = $signed(t.heading_mrad);
        lft = t.left_near_mm;
        rgt = t.right_near_mm;
        ml  = $signed(t.manual_linear);
        ma  = $signed(t.manual_angular);
        rnd = $signed(t.random_turn_mrad);
        fs  = tune.forward_speed;
        tr  = tune.turn_rate;
        ws  = tune.wander_step;
        db  = tune.override_deadband;

        // capture the start pose on the first tick
        if (!pose_captured) begin
            pose_ref_x    = px;
            pose_ref_y    = py;
            turn_base_hd  = hd;
            pose_captured = 1'b1;
        end
        lin = fs;
        ang = 0;

        // wander turn once far enough from the anchor in clear space
        dx = px - pose_ref_x;
        dy = py - pose_ref_y;
        if (dx * dx + dy * dy > ws * ws && !spin_active &&
            lft > longint'(tune.clear_distance) && rgt > longint'(tune.clear_distance)) begin
            turn_left    = rnd;
            turn_base_hd = hd;
            pose_ref_x   = px;
            pose_ref_y   = py;
        end

        // swerve from a one-sided obstacle
        if (lft < longint'(tune.swerve_distance)) begin
            ang = -tr;
            lin = fs >>> 1;
        end else if (rgt < longint'(tune.swerve_distance)) begin
            ang = tr;
            lin = fs >>> 1;
        end

        // both sides blocked: start the committed reverse turn
        if (lft < longint'(tune.blocked_distance) && rgt < longint'(tune.blocked_distance) &&
            !spin_active) begin
            turn_left    = TURN_BACK;
            turn_base_hd = hd;
            spin_active  = 1'b1;
        end
        if (spin_active) lin = 0;

        // carry the pending turn on, measured against the wrapped heading
        span = hd - turn_base_hd;
        if (turn_left > 0) begin
            if (span > WRAP_L) span -= WRAP_L;
            if (span < 0) span += WRAP_L;
            if (turn_left > span) begin
                ang = tr;
            end else begin
                turn_left   = 0;
                spin_active = 1'b0;
            end
        end else if (turn_left < 0) begin
            if (span > 0) span -= WRAP_L;
            if (span < -WRAP_L) span += WRAP_L;
            if (turn_left < span) begin
                ang = -tr;
            end else begin
                turn_left   = 0;
                spin_active = 1'b0;
            end
        end

        // teleop beats every autonomous behaviour
        if ((ml < 0 ? -ml : ml) > db || (ma < 0 ? -ma : ma) > db) begin
            lin         = ml;
            ang         = ma;
            turn_left   = 0;
            spin_active = 1'b0;
        end
        if (t.bumper_pressed) lin = 0;

        if (lin > LIN_CAP) lin = LIN_CAP;
        if (lin < -LIN_CAP) lin = -LIN_CAP;
        if (ang > ANG_CAP) ang = ANG_CAP;
        if (ang < -ANG_CAP) ang = -ANG_CAP;
        last_ang_cmd = ang;
        return make_cmd(lin, ang, spin_active);
    endfunction

    function automatic logic [DIST_W-1:0] side_gap();
        int pick;
        int hi;
        pick = $urandom_range(99);
        if (pick < 50) return DIST_W'($urandom_range(16383, tune.clear_distance));
        if (pick < 75) begin
            hi = int'(tune.swerve_distance) + 50;
            if (hi > 16383) hi = 16383;
            return DIST_W'($urandom_range(hi, 0));
        end
        return DIST_W'($urandom_range(16383, 0));
    endfunction

    // Next tick of a random roam; a few ticks are pure noise
    function automatic rwaa_pkg::t_item roam_tick();
        rwaa_pkg::t_item t;
        logic [127:0]    noise;
        int              pick;
        int              db;
        pick = $urandom_range(99);
        if (pick < 8) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            t = noise[$bits(rwaa_pkg::t_item)-1:0];
            return t;
        end
        // advance the pose, following the commanded turn direction
        if (pick < 12) begin
            walk_x = int'($urandom);
            walk_y = int'($urandom);
        end else begin
            walk_x += int'($urandom_range(300, 0)) - 150;
            walk_y += int'($urandom_range(300, 0)) - 150;
        end
        if (last_ang_cmd > 0) walk_hd += int'($urandom_range(500, 30));
        else if (last_ang_cmd < 0) walk_hd -= int'($urandom_range(500, 30));
        else walk_hd += int'($urandom_range(60, 0)) - 30;
        if (walk_hd > FULL_TURN_MRAD / 2) walk_hd -= FULL_TURN_MRAD;
        else if (walk_hd < -(FULL_TURN_MRAD / 2)) walk_hd += FULL_TURN_MRAD;

        t.pos_x_mm      = POS_W'(walk_x);
        t.pos_y_mm      = POS_W'(walk_y);
        t.heading_mrad  = HDG_W'(walk_hd);
        t.left_near_mm  = side_gap();
        t.right_near_mm = side_gap();
        if ($urandom_range(99) < 10) begin
            t.left_near_mm  = DIST_W'($urandom_range(tune.blocked_distance, 0));
            t.right_near_mm = DIST_W'($urandom_range(tune.blocked_distance, 0));
        end
        // teleop mostly idle inside the deadband
        db = tune.override_deadband;
        if ($urandom_range(99) < 85) begin
            t.manual_linear  = MLIN_W'(int'($urandom_range(2 * db, 0)) - db);
            t.manual_angular = MANG_W'(int'($urandom_range(2 * db, 0)) - db);
        end else begin
            t.manual_linear  = MLIN_W'($urandom);
            t.manual_angular = MANG_W'($urandom);
        end
        t.bumper_pressed   = ($urandom_range(99) < 8);
        t.random_turn_mrad = RND_W'($urandom);
        return t;
    endfunction

    // Offer one tick, with random idle cycles first; predict on acceptance
    task automatic send_tick(rwaa_pkg::t_item t, bit typed, rwaa_pkg::t_result want);
        rwaa_pkg::t_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 118){1'b0}}, t.random_turn_mrad, t.bumper_pressed,
                          t.manual_angular, t.manual_linear, t.right_near_mm,
                          t.left_near_mm, t.heading_mrad, t.pos_y_mm, t.pos_x_mm};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = arbitrate_tick(t);
        cmd_due_q.push_back(typed ? want : predicted);
    endtask

    // Hold the input side idle until every command has come back
    task automatic drain_commands();
        s_axis_tvalid <= 1'b0;
        while (cmd_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rwaa_pkg::CFG_FORWARD_SPEED:     tune.forward_speed     = val[FS_W-1:0];
            rwaa_pkg::CFG_TURN_RATE:         tune.turn_rate         = val[TR_W-1:0];
            rwaa_pkg::CFG_CLEAR_DISTANCE:    tune.clear_distance    = val;
            rwaa_pkg::CFG_SWERVE_DISTANCE:   tune.swerve_distance   = val;
            rwaa_pkg::CFG_BLOCKED_DISTANCE:  tune.blocked_distance  = val;
            rwaa_pkg::CFG_WANDER_STEP:       tune.wander_step       = val;
            rwaa_pkg::CFG_OVERRIDE_DEADBAND: tune.override_deadband = val[DB_W-1:0];
            default: ;
        endcase
    endtask

    // Load every tuning register, plus a write to the unused index
    task automatic load_tuning(int fs, int tr, int cd, int sd, int bd, int ws, int db);
        write_reg(rwaa_pkg::CFG_FORWARD_SPEED, CFG_DATA_W'(fs));
        write_reg(rwaa_pkg::CFG_TURN_RATE, CFG_DATA_W'(tr));
        write_reg(rwaa_pkg::CFG_CLEAR_DISTANCE, CFG_DATA_W'(cd));
        write_reg(rwaa_pkg::CFG_SWERVE_DISTANCE, CFG_DATA_W'(sd));
        write_reg(rwaa_pkg::CFG_BLOCKED_DISTANCE, CFG_DATA_W'(bd));
        write_reg(rwaa_pkg::CFG_WANDER_STEP, CFG_DATA_W'(ws));
        write_reg(rwaa_pkg::CFG_OVERRIDE_DEADBAND, CFG_DATA_W'(db));
        write_reg(CFG_IDX_SPARE, {CFG_DATA_W{1'b1}});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic roam(int count);
        rwaa_pkg::t_result none;
        none = make_cmd(0, 0, 1'b0);
        repeat (count) send_tick(roam_tick(), 1'b0, none);
    endtask

    task automatic report_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Randomise the output stall and check each command transaction
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cmd_due_q.size() == 0) begin
                $display("%0t: command with no tick outstanding, expected none got %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                report_field("linear_cmd", $signed(cmd_due_q[0].linear_cmd),
                             $signed(m_axis_tdata[10:0]));
                report_field("angular_cmd", $signed(cmd_due_q[0].angular_cmd),
                             $signed(m_axis_tdata[23:11]));
                report_field("turn_committed", cmd_due_q[0].turn_committed,
                             m_axis_tdata[24]);
                void'(cmd_due_q.pop_front());
            end
        end
    end

    initial begin
        // directed ticks under the reset tuning
        directed_q.push_back('{make_tick(1000, -2000, 500, 5000, 5000, 0, 0, 0, 100), 1'b1,
                               make_cmd(300, 0, 0)});
        directed_q.push_back('{make_tick(1400, -2000, 500, 5000, 5000, 0, 0, 0, 100), 1'b1,
                               make_cmd(300, 1000, 0)});
        directed_q.push_back('{make_tick(1400, -2000, 600, 5000, 5000, 0, 0, 0, 0), 1'b1,
                               make_cmd(300, 0, 0)});
        directed_q.push_back('{make_tick(1400, -2000, 600, 100, 5000, 0, 0, 0, 0), 1'b1,
                               make_cmd(150, -1000, 0)});
        directed_q.push_back('{make_tick(1400, -2000, 600, 5000, 200, 0, 0, 0, 0), 1'b1,
                               make_cmd(150, 1000, 0)});
        directed_q.push_back('{make_tick(1400, -2000, 600, 100, 100, 0, 0, 0, 0), 1'b1,
                               make_cmd(0, -1000, 1)});
        directed_q.push_back('{make_tick(1400, -2000, -2400, 5000, 5000, 0, 0, 0, 0), 1'b1,
                               make_cmd(0, -1000, 1)});
        directed_q.push_back('{make_tick(1400, -2000, -2540, 5000, 5000, 0, 0, 0, 0), 1'b1,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1400, -2000, -2540, 5000, 5000, -1000, 4000, 0, 0),
                               1'b1, make_cmd(-1000, 4000, 0)});
        directed_q.push_back('{make_tick(1400, -2000, -2540, 5000, 5000, 10, -10, 0, 0), 1'b1,
                               make_cmd(300, 0, 0)});
        directed_q.push_back('{make_tick(1400, -2000, -2540, 5000, 5000, 11, 0, 0, 0), 1'b1,
                               make_cmd(11, 0, 0)});
        directed_q.push_back('{make_tick(1400, -2000, -2540, 5000, 5000, 0, 0, 1, 0), 1'b1,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1400, -2000, 0, 50, 50, 0, 0, 1, 0), 1'b1,
                               make_cmd(0, -1000, 1)});
        directed_q.push_back('{make_tick(1400, -2000, 0, 5000, 5000, 0, -4000, 0, 0), 1'b1,
                               make_cmd(0, -4000, 0)});
        // positive turn across the heading wrap
        directed_q.push_back('{make_tick(1400, -1600, 4000, 5000, 5000, 0, 0, 0, 262), 1'b0,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1400, -1600, -2200, 5000, 5000, 0, 0, 0, 0), 1'b0,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1400, -1600, -2000, 5000, 5000, 0, 0, 0, 0), 1'b0,
                               make_cmd(0, 0, 0)});
        // random offset at the field minimum, then the negative wrap
        directed_q.push_back('{make_tick(1400, -1200, -4096, 5000, 5000, 0, 0, 0, -512), 1'b0,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1400, -1200, 4095, 5000, 5000, 0, 0, 0, 0), 1'b0,
                               make_cmd(0, 0, 0)});
        // zero offset still moves the anchor
        directed_q.push_back('{make_tick(1400, -800, 0, 5000, 5000, 0, 0, 0, 0), 1'b0,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(-1048576, 1048575, 0, 9000, 9000, 0, 0, 0, -262),
                               1'b0, make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1048575, -1048576, 100, 9000, 9000, 0, 0, 0, 511),
                               1'b0, make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1048575, -1048576, 200, 16383, 0, 0, 0, 0, 0), 1'b0,
                               make_cmd(0, 0, 0)});
        directed_q.push_back('{make_tick(1048575, -1048576, 200, 0, 16383, -1024, -4096, 0, 0),
                               1'b1, make_cmd(-1000, -4000, 0)});
        directed_q.push_back('{make_tick(1048575, -1048576, 200, 5000, 5000, 1023, 4095, 1, 0),
                               1'b1, make_cmd(0, 4000, 0)});

        // hold reset, then release
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: sender idles a third of the time, receiver over half
        tx_idle_pct = 33;
        rx_idle_pct = 54;
        foreach (directed_q[k]) send_tick(directed_q[k].tick, directed_q[k].typed,
                                          directed_q[k].want);
        drain_commands();
        load_tuning(500, 2000, 800, 400, 300, 200, 20);
        roam(220);

        // phase two: idle rates swapped, distances, step and deadband at zero, speed and turn rate at maximum
        drain_commands();
        tx_idle_pct = 54;
        rx_idle_pct = 33;
        load_tuning(1023, 4095, 0, 0, 0, 0, 0);
        roam(220);

        // phase three: no idling, zero speed and turn rate with all-ones other registers, then a busy tuning
        drain_commands();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_tuning(0, 0, 16383, 16383, 16383, 16383, 127);
        roam(60);
        drain_commands();
        load_tuning(1000, 4000, 1500, 700, 500, 1000, 100);
        roam(200);

        drain_commands();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
